/* design/lmse_pkg.sv */
`default_nettype none

package lmse_pkg;

  // fixed-point formats
  localparam int POINT_FRAC_BITS = 8;
  localparam int DIR_FRAC_BITS   = 14;

  // datapath widths
  localparam int PT_W   = 19;  // input point
  localparam int SM_W   = 20;  // smoothed point
  localparam int DIR_W  = 16;  // direction
  localparam int CW     = 12;  // centre / error
  localparam int PROD_W = 40;  // shared multiplier product
  localparam int DIV_W  = 36;  // divider dividend / quotient
  localparam int DVS_W  = 16;  // divisor
  localparam int IN_W   = 144; // input tdata
  localparam int OUT_W  = 40;  // output tdata
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH = 3'd0,
    CFG_LOOKAHEAD   = 3'd1,
    CFG_MAX_STEER   = 3'd2,
    CFG_EMA_ALPHA   = 3'd3,
    CFG_DEAD_BAND   = 3'd4
  } cfg_idx_e;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_COPY,
    OP_BMUL,
    OP_BACC,
    OP_SQX,
    OP_SQY,
    OP_SQSUM,
    OP_SQRT_GO,
    OP_NX_GO,
    OP_NX_WR,
    OP_NY_GO,
    OP_NY_WR,
    OP_DIR_WR,
    OP_XMUL,
    OP_X_GO,
    OP_X_ACC,
    OP_CENTRE,
    OP_DBMUL,
    OP_SMUL,
    OP_S_GO,
    OP_STEER
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       load;
    logic       lane;
    logic [1:0] fsel;
  } cmd_t;

  typedef struct packed {
    logic lane_vin;
    logic lane_sv;
    logic norm_zero;
    logic upd_ok;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } sts_t;

  function automatic logic signed [19:0] sat20(input logic signed [39:0] v);
    if (v > 40'sd524287) return 20'sd524287;
    if (v < -40'sd524288) return -20'sd524288;
    return v[19:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) return 16'sd32767;
    if (v < -40'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic logic signed [11:0] sat12(input logic signed [39:0] v);
    if (v > 40'sd2047) return 12'sd2047;
    if (v < -40'sd2048) return -12'sd2048;
    return v[11:0];
  endfunction

endpackage

`default_nettype wire

/* design/lmse_div.sv */
`default_nettype none

// unsigned restoring divider, one quotient bit per cycle
module lmse_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lmse_pkg::DIV_W-1:0]  dividend_i,
  input  logic [lmse_pkg::DVS_W-1:0]  divisor_i,
  output logic [lmse_pkg::DIV_W-1:0]  quotient_o,
  output logic                        done_o
);

  localparam int CNT_W = $clog2(lmse_pkg::DIV_W);

  logic                        busy_q;
  logic                        done_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [lmse_pkg::DIV_W-1:0]  quo_q;
  logic [lmse_pkg::DVS_W-1:0]  rem_q;
  logic [lmse_pkg::DVS_W-1:0]  dvs_q;
  logic [lmse_pkg::DVS_W:0]    sh;
  logic                        fits;

  // trial subtract
  assign sh   = {rem_q, quo_q[lmse_pkg::DIV_W-1]};
  assign fits = sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(lmse_pkg::DIV_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[lmse_pkg::DIV_W-2:0], fits};
      rem_q <= fits ? lmse_pkg::DVS_W'(sh - {1'b0, dvs_q}) : sh[lmse_pkg::DVS_W-1:0];
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

/* design/lmse_isqrt.sv */
`default_nettype none

// integer square root, one result bit per cycle
module lmse_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] rad_i,
  output logic [15:0] root_o,
  output logic        done_o
);

  logic        busy_q;
  logic        done_q;
  logic [3:0]  cnt_q;
  logic [31:0] v_q;
  logic [31:0] r_q;
  logic [31:0] bitv;
  logic [31:0] trial;

  assign bitv  = 32'd1 << {cnt_q, 1'b0};
  assign trial = r_q + bitv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd15;
      end else if (busy_q) begin
        if (cnt_q == 4'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= rad_i;
      r_q <= '0;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bitv;
      end else begin
        r_q <= r_q >> 1;
      end
    end
  end

  assign root_o = r_q[15:0];
  assign done_o = done_q;

endmodule

`default_nettype wire

/* design/lmse_dp.sv */
`default_nettype none

module lmse_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lmse_pkg::cmd_t                    cmd_i,
  output lmse_pkg::sts_t                    sts_o,
  input  logic [lmse_pkg::IN_W-1:0]         in_data_i,
  input  logic [1:0]                        in_user_i,
  input  logic                              cfg_valid_i,
  input  logic [lmse_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lmse_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lmse_pkg::OUT_W-1:0]        out_data_o,
  output logic                              out_user_o
);

  // configuration
  logic [11:0] width_q;
  logic [10:0] row_q;
  logic [14:0] maxs_q;
  logic [16:0] alpha_q;
  logic [15:0] dead_q;

  // latched frame
  logic                vin_q  [2];
  logic signed [18:0]  in_px_q [2];
  logic signed [18:0]  in_py_q [2];
  logic signed [15:0]  in_dx_q [2];
  logic signed [15:0]  in_dy_q [2];

  // smoothed lane models
  logic                sv_q  [2];
  logic signed [19:0]  spx_q [2];
  logic signed [19:0]  spy_q [2];
  logic signed [15:0]  sdx_q [2];
  logic signed [15:0]  sdy_q [2];

  // held results
  logic signed [11:0]  held_err_q;
  logic signed [11:0]  held_cen_q;
  logic                upd_q;

  // work registers
  logic signed [16:0]  bdx_q;
  logic signed [16:0]  bdy_q;
  logic signed [39:0]  prod_q;
  logic [31:0]         sq_q;
  logic signed [39:0]  xs_q;
  logic                neg_q;
  logic                dz_q;

  // output word
  logic                out_valid_q;
  logic signed [15:0]  out_steer_q;
  logic signed [11:0]  out_cen_q;
  logic signed [11:0]  out_err_q;
  logic                out_upd_q;

  logic                lane;
  logic [10:0]         half;
  logic [16:0]         a_sat;
  logic [11:0]         mag;
  logic signed [20:0]  cur_v;
  logic signed [20:0]  old_v;
  logic signed [21:0]  ma;
  logic signed [17:0]  mb;
  logic signed [39:0]  mprod;
  logic signed [39:0]  bl;
  logic [16:0]         bdx_abs;
  logic [16:0]         bdy_abs;
  logic [16:0]         dy_abs;
  logic [39:0]         prod_abs;
  logic                div_start;
  logic [lmse_pkg::DIV_W-1:0] dvd;
  logic [lmse_pkg::DVS_W-1:0] dvs;
  logic [lmse_pkg::DIV_W-1:0] quo;
  logic                div_done;
  logic [15:0]         root;
  logic                sqrt_done;
  logic signed [39:0]  qs;
  logic signed [39:0]  lx;
  logic [39:0]         xs_abs;
  logic [30:0]         cmag;
  logic signed [39:0]  cs;
  logic [14:0]         stv;
  logic signed [15:0]  steer;

  assign lane  = cmd_i.lane;
  assign half  = (width_q[11:1] == 11'd0) ? 11'd1 : width_q[11:1];
  assign a_sat = (alpha_q > 17'd65536) ? 17'd65536 : alpha_q;
  assign mag   = held_err_q[11] ? 12'(-held_err_q) : 12'(held_err_q);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 12'd640;
      row_q   <= 11'd360;
      maxs_q  <= 15'd7680;
      alpha_q <= 17'd13107;
      dead_q  <= 16'd1311;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lmse_pkg::CFG_IMAGE_WIDTH: width_q <= cfg_data_i[11:0];
        lmse_pkg::CFG_LOOKAHEAD:   row_q   <= cfg_data_i[10:0];
        lmse_pkg::CFG_MAX_STEER:   maxs_q  <= cfg_data_i[14:0];
        lmse_pkg::CFG_EMA_ALPHA:   alpha_q <= cfg_data_i;
        lmse_pkg::CFG_DEAD_BAND:   dead_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // field select for blending
  always_comb begin
    case (cmd_i.fsel)
      2'd0: begin
        cur_v = 21'(in_px_q[lane]);
        old_v = 21'(spx_q[lane]);
      end
      2'd1: begin
        cur_v = 21'(in_py_q[lane]);
        old_v = 21'(spy_q[lane]);
      end
      2'd2: begin
        cur_v = 21'(in_dx_q[lane]);
        old_v = 21'(sdx_q[lane]);
      end
      default: begin
        cur_v = 21'(in_dy_q[lane]);
        old_v = 21'(sdy_q[lane]);
      end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      lmse_pkg::OP_BMUL: begin
        ma = 22'(cur_v) - 22'(old_v);
        mb = $signed({1'b0, a_sat});
      end
      lmse_pkg::OP_SQX: begin
        ma = 22'(bdx_q);
        mb = 18'(bdx_q);
      end
      lmse_pkg::OP_SQY: begin
        ma = 22'(bdy_q);
        mb = 18'(bdy_q);
      end
      lmse_pkg::OP_XMUL: begin
        ma = $signed(22'(row_q) << lmse_pkg::POINT_FRAC_BITS) - 22'(spy_q[lane]);
        mb = 18'(sdx_q[lane]);
      end
      lmse_pkg::OP_DBMUL: begin
        ma = $signed({6'd0, dead_q});
        mb = $signed({7'd0, half});
      end
      lmse_pkg::OP_SMUL: begin
        ma = $signed({10'd0, mag});
        mb = $signed({3'd0, maxs_q});
      end
      default: ;
    endcase
  end

  assign mprod = 40'(ma) * 40'(mb);
  assign bl    = 40'(old_v) + ((prod_q + 40'sd32768) >>> 16);

  // divider operands with half-away rounding
  assign bdx_abs  = bdx_q[16] ? 17'(-bdx_q) : 17'(bdx_q);
  assign bdy_abs  = bdy_q[16] ? 17'(-bdy_q) : 17'(bdy_q);
  assign dy_abs   = sdy_q[lane][15] ? 17'(-17'(sdy_q[lane])) : 17'(sdy_q[lane]);
  assign prod_abs = prod_q[39] ? 40'(-prod_q) : 40'(prod_q);

  always_comb begin
    div_start = 1'b1;
    dvd       = '0;
    dvs       = 16'd1;
    case (cmd_i.op)
      lmse_pkg::OP_NX_GO: begin
        dvd = (lmse_pkg::DIV_W'(bdx_abs) << lmse_pkg::DIR_FRAC_BITS)
              + lmse_pkg::DIV_W'(root >> 1);
        dvs = root;
      end
      lmse_pkg::OP_NY_GO: begin
        dvd = (lmse_pkg::DIV_W'(bdy_abs) << lmse_pkg::DIR_FRAC_BITS)
              + lmse_pkg::DIV_W'(root >> 1);
        dvs = root;
      end
      lmse_pkg::OP_X_GO: begin
        dvd = prod_abs[lmse_pkg::DIV_W-1:0] + lmse_pkg::DIV_W'(dy_abs >> 1);
        dvs = dy_abs[15:0];
      end
      lmse_pkg::OP_S_GO: begin
        dvd = prod_q[lmse_pkg::DIV_W-1:0] + lmse_pkg::DIV_W'(half >> 1);
        dvs = 16'(half);
      end
      default: div_start = 1'b0;
    endcase
  end

  lmse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  lmse_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == lmse_pkg::OP_SQRT_GO),
    .rad_i   (sq_q),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  // signed quotient, lane x, centre and steering
  assign qs     = neg_q ? -$signed({4'd0, quo}) : $signed({4'd0, quo});
  assign lx     = 40'(spx_q[lane]) + qs;
  assign xs_abs = xs_q[39] ? 40'(-xs_q) : 40'(xs_q);
  assign cmag   = 31'(xs_abs >> (lmse_pkg::POINT_FRAC_BITS + 1));
  assign cs     = xs_q[39] ? -$signed({9'd0, cmag}) : $signed({9'd0, cmag});
  assign stv    = (quo > lmse_pkg::DIV_W'(maxs_q)) ? maxs_q : quo[14:0];
  assign steer  = dz_q ? 16'sd0 : (held_err_q[11] ? -$signed({1'b0, stv})
                                                  : $signed({1'b0, stv}));

  // control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0]     <= 1'b0;
      sv_q[1]     <= 1'b0;
      held_err_q  <= '0;
      held_cen_q  <= '0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) upd_q <= 1'b0;
      if (cmd_i.op == lmse_pkg::OP_COPY) sv_q[lane] <= 1'b1;
      if (cmd_i.op == lmse_pkg::OP_CENTRE) begin
        held_cen_q <= lmse_pkg::sat12(cs);
        held_err_q <= lmse_pkg::sat12(cs - 40'(half));
        upd_q      <= 1'b1;
      end
      if (cmd_i.op == lmse_pkg::OP_STEER) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vin_q[0]   <= in_user_i[0];
      vin_q[1]   <= in_user_i[1];
      in_px_q[0] <= $signed(in_data_i[18:0]);
      in_py_q[0] <= $signed(in_data_i[37:19]);
      in_dx_q[0] <= $signed(in_data_i[53:38]);
      in_dy_q[0] <= $signed(in_data_i[69:54]);
      in_px_q[1] <= $signed(in_data_i[88:70]);
      in_py_q[1] <= $signed(in_data_i[107:89]);
      in_dx_q[1] <= $signed(in_data_i[123:108]);
      in_dy_q[1] <= $signed(in_data_i[139:124]);
    end
    case (cmd_i.op)
      lmse_pkg::OP_COPY: begin
        spx_q[lane] <= 20'(in_px_q[lane]);
        spy_q[lane] <= 20'(in_py_q[lane]);
        sdx_q[lane] <= in_dx_q[lane];
        sdy_q[lane] <= in_dy_q[lane];
      end
      lmse_pkg::OP_BMUL, lmse_pkg::OP_SQX, lmse_pkg::OP_XMUL,
      lmse_pkg::OP_DBMUL: prod_q <= mprod;
      lmse_pkg::OP_BACC: begin
        case (cmd_i.fsel)
          2'd0:    spx_q[lane] <= lmse_pkg::sat20(bl);
          2'd1:    spy_q[lane] <= lmse_pkg::sat20(bl);
          2'd2:    bdx_q <= bl[16:0];
          default: bdy_q <= bl[16:0];
        endcase
      end
      lmse_pkg::OP_SQY: begin
        sq_q   <= prod_q[31:0];
        prod_q <= mprod;
      end
      lmse_pkg::OP_SQSUM: sq_q <= sq_q + prod_q[31:0];
      lmse_pkg::OP_NX_GO: neg_q <= bdx_q[16];
      lmse_pkg::OP_NY_GO: neg_q <= bdy_q[16];
      lmse_pkg::OP_X_GO:  neg_q <= prod_q[39] ^ sdy_q[lane][15];
      lmse_pkg::OP_S_GO:  neg_q <= held_err_q[11];
      lmse_pkg::OP_NX_WR: bdx_q <= 17'(lmse_pkg::sat16(qs));
      lmse_pkg::OP_NY_WR: bdy_q <= 17'(lmse_pkg::sat16(qs));
      lmse_pkg::OP_DIR_WR: begin
        sdx_q[lane] <= bdx_q[15:0];
        sdy_q[lane] <= bdy_q[15:0];
      end
      lmse_pkg::OP_X_ACC: xs_q <= lane ? xs_q + lx : lx;
      lmse_pkg::OP_SMUL: begin
        dz_q   <= {mag, 16'd0} < prod_q[27:0];
        prod_q <= mprod;
      end
      lmse_pkg::OP_STEER: begin
        out_steer_q <= steer;
        out_cen_q   <= held_cen_q;
        out_err_q   <= held_err_q;
        out_upd_q   <= upd_q;
      end
      default: ;
    endcase
  end

  // status to the controller
  assign sts_o.lane_vin  = vin_q[lane];
  assign sts_o.lane_sv   = sv_q[lane];
  assign sts_o.norm_zero = (root == 16'd0);
  assign sts_o.upd_ok    = sv_q[0] && sv_q[1] && (sdy_q[0] != 16'sd0) && (sdy_q[1] != 16'sd0);
  assign sts_o.div_done  = div_done;
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_err_q, out_cen_q, out_steer_q};
  assign out_user_o  = out_upd_q;

endmodule

`default_nettype wire

/* design/lmse_ctrl.sv */
`default_nettype none

module lmse_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lmse_pkg::sts_t sts_i,
  output lmse_pkg::cmd_t cmd_o
);

  typedef enum logic [27:0] {
    S_IDLE  = 28'd1 << 0,
    S_LANE  = 28'd1 << 1,
    S_COPY  = 28'd1 << 2,
    S_BMUL  = 28'd1 << 3,
    S_BACC  = 28'd1 << 4,
    S_SQX   = 28'd1 << 5,
    S_SQY   = 28'd1 << 6,
    S_SQS   = 28'd1 << 7,
    S_SQRT  = 28'd1 << 8,
    S_SQW   = 28'd1 << 9,
    S_NXG   = 28'd1 << 10,
    S_NXW   = 28'd1 << 11,
    S_NXWR  = 28'd1 << 12,
    S_NYG   = 28'd1 << 13,
    S_NYW   = 28'd1 << 14,
    S_NYWR  = 28'd1 << 15,
    S_DIRW  = 28'd1 << 16,
    S_CCHK  = 28'd1 << 17,
    S_XMUL  = 28'd1 << 18,
    S_XG    = 28'd1 << 19,
    S_XW    = 28'd1 << 20,
    S_XACC  = 28'd1 << 21,
    S_CENT  = 28'd1 << 22,
    S_DBMUL = 28'd1 << 23,
    S_SMUL  = 28'd1 << 24,
    S_SG    = 28'd1 << 25,
    S_SW    = 28'd1 << 26,
    S_OUT   = 28'd1 << 27
  } state_e;

  state_e     state_q, state_d;
  logic       lane_q, lane_d;
  logic [1:0] f_q, f_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lane_q  <= 1'b0;
      f_q     <= 2'd0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
      f_q     <= f_d;
    end
  end

  // sequencing
  always_comb begin
    state_d     = state_q;
    lane_d      = lane_q;
    f_d         = f_q;
    cmd_o.op    = lmse_pkg::OP_NONE;
    cmd_o.load  = accept;
    cmd_o.lane  = lane_q;
    cmd_o.fsel  = f_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          lane_d  = 1'b0;
          state_d = S_LANE;
        end
      end
      S_LANE: begin
        f_d = 2'd0;
        if (!sts_i.lane_vin) begin
          lane_d  = 1'b1;
          state_d = lane_q ? S_CCHK : S_LANE;
        end else if (!sts_i.lane_sv) begin
          state_d = S_COPY;
        end else begin
          state_d = S_BMUL;
        end
      end
      S_COPY: begin
        cmd_o.op = lmse_pkg::OP_COPY;
        lane_d   = 1'b1;
        state_d  = lane_q ? S_CCHK : S_LANE;
      end
      S_BMUL: begin
        cmd_o.op = lmse_pkg::OP_BMUL;
        state_d  = S_BACC;
      end
      S_BACC: begin
        cmd_o.op = lmse_pkg::OP_BACC;
        f_d      = f_q + 2'd1;
        state_d  = (f_q == 2'd3) ? S_SQX : S_BMUL;
      end
      S_SQX: begin
        cmd_o.op = lmse_pkg::OP_SQX;
        state_d  = S_SQY;
      end
      S_SQY: begin
        cmd_o.op = lmse_pkg::OP_SQY;
        state_d  = S_SQS;
      end
      S_SQS: begin
        cmd_o.op = lmse_pkg::OP_SQSUM;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = lmse_pkg::OP_SQRT_GO;
        state_d  = S_SQW;
      end
      S_SQW: begin
        if (sts_i.sqrt_done) state_d = sts_i.norm_zero ? S_DIRW : S_NXG;
      end
      S_NXG: begin
        cmd_o.op = lmse_pkg::OP_NX_GO;
        state_d  = S_NXW;
      end
      S_NXW: begin
        if (sts_i.div_done) state_d = S_NXWR;
      end
      S_NXWR: begin
        cmd_o.op = lmse_pkg::OP_NX_WR;
        state_d  = S_NYG;
      end
      S_NYG: begin
        cmd_o.op = lmse_pkg::OP_NY_GO;
        state_d  = S_NYW;
      end
      S_NYW: begin
        if (sts_i.div_done) state_d = S_NYWR;
      end
      S_NYWR: begin
        cmd_o.op = lmse_pkg::OP_NY_WR;
        state_d  = S_DIRW;
      end
      S_DIRW: begin
        cmd_o.op = lmse_pkg::OP_DIR_WR;
        lane_d   = 1'b1;
        state_d  = lane_q ? S_CCHK : S_LANE;
      end
      S_CCHK: begin
        lane_d  = 1'b0;
        state_d = sts_i.upd_ok ? S_XMUL : S_DBMUL;
      end
      S_XMUL: begin
        cmd_o.op = lmse_pkg::OP_XMUL;
        state_d  = S_XG;
      end
      S_XG: begin
        cmd_o.op = lmse_pkg::OP_X_GO;
        state_d  = S_XW;
      end
      S_XW: begin
        if (sts_i.div_done) state_d = S_XACC;
      end
      S_XACC: begin
        cmd_o.op = lmse_pkg::OP_X_ACC;
        lane_d   = 1'b1;
        state_d  = lane_q ? S_CENT : S_XMUL;
      end
      S_CENT: begin
        cmd_o.op = lmse_pkg::OP_CENTRE;
        state_d  = S_DBMUL;
      end
      S_DBMUL: begin
        cmd_o.op = lmse_pkg::OP_DBMUL;
        state_d  = S_SMUL;
      end
      S_SMUL: begin
        cmd_o.op = lmse_pkg::OP_SMUL;
        state_d  = S_SG;
      end
      S_SG: begin
        cmd_o.op = lmse_pkg::OP_S_GO;
        state_d  = S_SW;
      end
      S_SW: begin
        if (sts_i.div_done) state_d = S_OUT;
      end
      S_OUT: begin
        // hand over once the output register is free
        if (sts_i.out_free) begin
          cmd_o.op = lmse_pkg::OP_STEER;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* design/lane_model_steering_estimator_unit.sv */
// Lane model smoothing and proportional steering estimator.
// Input stream: one word per frame. tuser carries the two lane valid flags,
// tdata the fitted left and right lines (point Q11.8, direction Q1.14).
// Output stream: one word per input word with steering angle (Q8.8), lane
// centre and lateral error in whole pixels; tuser says whether the centre
// was recomputed this frame or held.
// Config channel: index plus data, always ready; write only while idle.
// A frame takes longest when both lanes blend and the centre is
// recomputed, less when lanes are copied or skipped. The cost is set by
// seven passes through the shared serial divider (four direction
// renormalizations, two lane x evaluations, one steering scale) plus a
// square root per blended lane. One frame is processed at a time;
// s_axis_tready is high only while the sequencer is idle.
// Reset clears both lane models, the held centre and error, and restores
// the default registers. A stalled receiver holds the result in the output
// register; the next frame is still taken and its result waits in S_OUT.
`default_nettype none

module lane_model_steering_estimator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // left_px, left_py, left_dx, left_dy, right_px, right_py, right_dx, right_dy
  input  logic [lmse_pkg::IN_W-1:0]        s_axis_tdata,
  // left_valid, right_valid
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // steer_q88, centre_x, lat_error
  output logic [lmse_pkg::OUT_W-1:0]       m_axis_tdata,
  // centre_updated
  output logic [0:0]                       m_axis_tuser,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lmse_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lmse_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  lmse_pkg::cmd_t cmd;
  lmse_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  lmse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lmse_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser[0])
  );

  // one frame in flight in the sequencer
  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("frame accepted while sequencer busy");

  // results never overwrite an unread word
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == lmse_pkg::OP_STEER) |-> sts.out_free)
    else $error("output word overwritten");

  // renormalization never divides by a zero norm
  a_norm_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == lmse_pkg::OP_NX_GO || cmd.op == lmse_pkg::OP_NY_GO) |-> !sts.norm_zero)
    else $error("division by zero norm");

  // lane x is evaluated only with both lanes usable
  a_x_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == lmse_pkg::OP_X_GO) |-> sts.upd_ok)
    else $error("lane x evaluated without usable lanes");

endmodule

`default_nettype wire
